// ===== rtl/core/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dp, the top level and the checker; no dependencies.
`default_nettype none
package ffha_pkg;

    localparam int POOL_BYTES = 65536;
    localparam int HDR_BYTES  = (12 + 3) & ~3;
    localparam int WORDS      = POOL_BYTES / 4;
    localparam int IDX_W      = $clog2(WORDS);
    localparam int SIZE_W     = 17;
    localparam int POS_W      = SIZE_W + 1;
    localparam int SLACK_W    = 11;
    localparam int SLACK_RST  = 32;

    typedef enum logic [2:0] {
        ST_ALLOC  = 3'd0,
        ST_FAIL   = 3'd1,
        ST_FREED  = 3'd2,
        ST_BADPTR = 3'd3,
        ST_DOUBLE = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LATCH,
        OP_POS0,
        OP_RD_POS,
        OP_RD_NX,
        OP_LD_CUR,
        OP_LD_NXT,
        OP_WALK_ADV,
        OP_MERGE_W2,
        OP_MERGE_W1,
        OP_MERGE_ADV,
        OP_SPLIT_W,
        OP_TAKE,
        OP_FREE_DEC,
        OP_FREE_W
    } dp_op_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH,
        S_W_RD, S_W_LD, S_W_CHK, S_A_TAKE,
        S_M_RD, S_M_LD, S_M_CHK, S_M_LDN, S_M_DEC, S_M_W1,
        S_F_RD, S_F_LD, S_F_CHK, S_F_LDN, S_F_DEC, S_F_W, S_F_W1, S_M_W1_F,
        S_RESP
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        logic    res_en;
        status_t res_code;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic cmd_free;
        logic bad;
        logic fit;
        logic split_ok;
        logic cur_zero;
        logic nx_over;
        logic cur_used;
        logic cur_start;
        logic nxt_used;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic              start;
        logic              used;
        logic [SIZE_W-1:0] size;
    } mem_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/ffha_dp.sv =====
// Datapath of the allocator: block table memory, walk registers, totals, result register.
// Depends on ffha_pkg; driven by ffha_ctrl through dp_cmd_t.
`default_nettype none
module ffha_dp (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire ffha_pkg::dp_cmd_t      cmd,
    output ffha_pkg::dp_stat_t          stat,
    input  wire                         in_cmd,
    input  wire [31:0]                  in_req,
    input  wire [31:0]                  in_ptr,
    input  wire                         cfg_fire,
    input  wire [ffha_pkg::SLACK_W-1:0] cfg_slack,
    output logic                        out_valid,
    input  wire                         out_ready,
    output ffha_pkg::status_t           out_status,
    output logic [15:0]                 out_addr,
    output logic [ffha_pkg::SIZE_W-1:0] out_used
);
    localparam int PW = ffha_pkg::POS_W;
    localparam int SW = ffha_pkg::SIZE_W;
    localparam int IW = ffha_pkg::IDX_W;
    localparam logic [PW-1:0] POOL_P = PW'(ffha_pkg::POOL_BYTES);
    localparam logic [PW-1:0] HDR_P  = PW'(ffha_pkg::HDR_BYTES);

    ffha_pkg::mem_word_t mem [ffha_pkg::WORDS];
    ffha_pkg::mem_word_t rd_data_reg;

    logic [ffha_pkg::SLACK_W-1:0] slack_reg;
    logic                         cmd_reg, bad_reg;
    logic [PW-1:0]                need_reg, pos_reg;
    logic [SW-1:0]                cur_size_reg, nxt_size_reg, used_reg;
    logic                         cur_used_reg, cur_start_reg, nxt_used_reg;
    logic [IW-1:0]                clr_reg;
    logic                         out_valid_reg;
    ffha_pkg::status_t            out_status_reg;
    logic [15:0]                  out_addr_reg;
    logic [SW-1:0]                out_used_reg;

    logic [PW-1:0]       nx, split_pos, req_need, ptr_pos;
    logic                req_bad, ptr_bad;
    logic                wr_en, rd_en;
    logic [IW-1:0]       wr_idx, rd_idx;
    ffha_pkg::mem_word_t wr_word;

    assign nx        = pos_reg + {1'b0, cur_size_reg};
    assign split_pos = pos_reg + need_reg;
    assign req_need  = ((PW'(in_req[SW-1:0]) + PW'(3)) & ~PW'(3)) + HDR_P;
    assign req_bad   = (in_req == 32'd0) || (in_req > 32'(ffha_pkg::POOL_BYTES));
    assign ptr_pos   = PW'(in_ptr - 32'(ffha_pkg::HDR_BYTES));
    assign ptr_bad   = (in_ptr < 32'(ffha_pkg::HDR_BYTES))
                    || ((in_ptr - 32'(ffha_pkg::HDR_BYTES)) >= 32'(ffha_pkg::POOL_BYTES))
                    || (in_ptr[1:0] != 2'(ffha_pkg::HDR_BYTES));

    assign stat.clr_last  = (clr_reg == IW'(ffha_pkg::WORDS - 1));
    assign stat.cmd_free  = cmd_reg;
    assign stat.bad       = bad_reg;
    assign stat.fit       = !cur_used_reg && ({1'b0, cur_size_reg} >= need_reg);
    assign stat.split_ok  = {1'b0, cur_size_reg}
                            >= need_reg + HDR_P + PW'(slack_reg);
    assign stat.cur_zero  = (cur_size_reg == '0);
    assign stat.nx_over   = (nx >= POOL_P);
    assign stat.cur_used  = cur_used_reg;
    assign stat.cur_start = cur_start_reg;
    assign stat.nxt_used  = nxt_used_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    // memory port selection per operation
    always_comb
    begin
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        wr_idx  = pos_reg[IW+1:2];
        rd_idx  = pos_reg[IW+1:2];
        wr_word = '{start: 1'b1, used: 1'b0, size: cur_size_reg};
        case (cmd.op)
            ffha_pkg::OP_CLR:
            begin
                wr_en   = 1'b1;
                wr_idx  = clr_reg;
                wr_word = '{start: (clr_reg == '0), used: 1'b0,
                            size: (clr_reg == '0) ? SW'(ffha_pkg::POOL_BYTES) : '0};
            end
            ffha_pkg::OP_RD_POS: rd_en = 1'b1;
            ffha_pkg::OP_RD_NX:
            begin
                rd_en  = 1'b1;
                rd_idx = nx[IW+1:2];
            end
            ffha_pkg::OP_MERGE_W2:
            begin
                wr_en   = 1'b1;
                wr_idx  = nx[IW+1:2];
                wr_word = '{start: 1'b0, used: 1'b0, size: nxt_size_reg};
            end
            ffha_pkg::OP_MERGE_W1:
            begin
                wr_en        = 1'b1;
                wr_word.size = cur_size_reg + nxt_size_reg;
            end
            ffha_pkg::OP_SPLIT_W:
            begin
                wr_en        = 1'b1;
                wr_idx       = split_pos[IW+1:2];
                wr_word.size = cur_size_reg - need_reg[SW-1:0];
            end
            ffha_pkg::OP_TAKE:
            begin
                wr_en        = 1'b1;
                wr_word.used = 1'b1;
            end
            ffha_pkg::OP_FREE_W: wr_en = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_word;
        if (rd_en)
            rd_data_reg <= mem[rd_idx];
    end

    // walk registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ffha_pkg::OP_LATCH:
            begin
                cmd_reg  <= in_cmd;
                bad_reg  <= in_cmd ? ptr_bad : req_bad;
                need_reg <= req_need;
                pos_reg  <= in_cmd ? ptr_pos : '0;
            end
            ffha_pkg::OP_POS0:    pos_reg <= '0;
            ffha_pkg::OP_LD_CUR:
            begin
                cur_size_reg  <= rd_data_reg.size;
                cur_used_reg  <= rd_data_reg.used;
                cur_start_reg <= rd_data_reg.start;
            end
            ffha_pkg::OP_LD_NXT:
            begin
                nxt_size_reg <= rd_data_reg.size;
                nxt_used_reg <= rd_data_reg.used;
            end
            ffha_pkg::OP_WALK_ADV: pos_reg <= nx;
            ffha_pkg::OP_MERGE_W1: cur_size_reg <= cur_size_reg + nxt_size_reg;
            ffha_pkg::OP_MERGE_ADV:
            begin
                pos_reg      <= nx;
                cur_size_reg <= nxt_size_reg;
                cur_used_reg <= nxt_used_reg;
            end
            ffha_pkg::OP_SPLIT_W: cur_size_reg <= need_reg[SW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slack_reg     <= ffha_pkg::SLACK_W'(ffha_pkg::SLACK_RST);
            used_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
                slack_reg <= cfg_slack;
            if (cmd.op == ffha_pkg::OP_CLR)
                clr_reg <= clr_reg + IW'(1);
            if (cmd.op == ffha_pkg::OP_TAKE)
                used_reg <= used_reg + cur_size_reg;
            if (cmd.op == ffha_pkg::OP_FREE_DEC)
                used_reg <= used_reg - cur_size_reg;
            if (cmd.res_en)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_en)
        begin
            out_status_reg <= cmd.res_code;
            out_addr_reg   <= (cmd.res_code == ffha_pkg::ST_ALLOC)
                              ? 16'(pos_reg + HDR_P) : 16'd0;
            out_used_reg   <= used_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_addr   = out_addr_reg;
    assign out_used   = out_used_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ffha_ctrl.sv =====
// Sequencer for clearing, first-fit walk, merge pass, split and free.
// Depends on ffha_pkg; commands ffha_dp, reads its status flags.
`default_nettype none
module ffha_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire ffha_pkg::dp_stat_t stat,
    output ffha_pkg::dp_cmd_t       cmd
);
    ffha_pkg::state_t  state_reg, state_next;
    logic              pass_reg, pass_next;
    ffha_pkg::status_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::S_CLEAR;
            pass_reg  <= 1'b0;
            code_reg  <= ffha_pkg::ST_FAIL;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        code_next    = code_reg;
        in_ready     = 1'b0;
        cmd.op       = ffha_pkg::OP_NONE;
        cmd.res_en   = 1'b0;
        cmd.res_code = code_reg;
        case (state_reg)
            ffha_pkg::S_CLEAR:
            begin
                cmd.op = ffha_pkg::OP_CLR;
                if (stat.clr_last)
                    state_next = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = ffha_pkg::OP_LATCH;
                    state_next = ffha_pkg::S_DISPATCH;
                end
            end
            ffha_pkg::S_DISPATCH:
            begin
                pass_next = 1'b0;
                if (stat.bad)
                begin
                    code_next  = stat.cmd_free ? ffha_pkg::ST_BADPTR : ffha_pkg::ST_FAIL;
                    state_next = ffha_pkg::S_RESP;
                end
                else
                    state_next = stat.cmd_free ? ffha_pkg::S_F_RD : ffha_pkg::S_W_RD;
            end
            ffha_pkg::S_W_RD:
            begin
                cmd.op     = ffha_pkg::OP_RD_POS;
                state_next = ffha_pkg::S_W_LD;
            end
            ffha_pkg::S_W_LD:
            begin
                cmd.op     = ffha_pkg::OP_LD_CUR;
                state_next = ffha_pkg::S_W_CHK;
            end
            ffha_pkg::S_W_CHK:
            begin
                if (stat.fit)
                begin
                    if (stat.split_ok)
                        cmd.op = ffha_pkg::OP_SPLIT_W;
                    state_next = ffha_pkg::S_A_TAKE;
                end
                else if (stat.cur_zero || stat.nx_over)
                begin
                    if (pass_reg)
                    begin
                        code_next  = ffha_pkg::ST_FAIL;
                        state_next = ffha_pkg::S_RESP;
                    end
                    else
                    begin
                        cmd.op     = ffha_pkg::OP_POS0;
                        state_next = ffha_pkg::S_M_RD;
                    end
                end
                else
                begin
                    cmd.op     = ffha_pkg::OP_WALK_ADV;
                    state_next = ffha_pkg::S_W_RD;
                end
            end
            ffha_pkg::S_A_TAKE:
            begin
                cmd.op     = ffha_pkg::OP_TAKE;
                code_next  = ffha_pkg::ST_ALLOC;
                state_next = ffha_pkg::S_RESP;
            end
            ffha_pkg::S_M_RD:
            begin
                cmd.op     = ffha_pkg::OP_RD_POS;
                state_next = ffha_pkg::S_M_LD;
            end
            ffha_pkg::S_M_LD:
            begin
                cmd.op     = ffha_pkg::OP_LD_CUR;
                state_next = ffha_pkg::S_M_CHK;
            end
            ffha_pkg::S_M_CHK:
            begin
                if (stat.cur_zero || stat.nx_over)
                begin
                    pass_next  = 1'b1;
                    cmd.op     = ffha_pkg::OP_POS0;
                    state_next = ffha_pkg::S_W_RD;
                end
                else
                begin
                    cmd.op     = ffha_pkg::OP_RD_NX;
                    state_next = ffha_pkg::S_M_LDN;
                end
            end
            ffha_pkg::S_M_LDN:
            begin
                cmd.op     = ffha_pkg::OP_LD_NXT;
                state_next = ffha_pkg::S_M_DEC;
            end
            ffha_pkg::S_M_DEC:
            begin
                if (!stat.cur_used && !stat.nxt_used)
                begin
                    cmd.op     = ffha_pkg::OP_MERGE_W2;
                    state_next = ffha_pkg::S_M_W1;
                end
                else
                begin
                    cmd.op     = ffha_pkg::OP_MERGE_ADV;
                    state_next = ffha_pkg::S_M_CHK;
                end
            end
            ffha_pkg::S_M_W1:
            begin
                cmd.op     = ffha_pkg::OP_MERGE_W1;
                state_next = ffha_pkg::S_M_CHK;
            end
            ffha_pkg::S_F_RD:
            begin
                cmd.op     = ffha_pkg::OP_RD_POS;
                state_next = ffha_pkg::S_F_LD;
            end
            ffha_pkg::S_F_LD:
            begin
                cmd.op     = ffha_pkg::OP_LD_CUR;
                state_next = ffha_pkg::S_F_CHK;
            end
            ffha_pkg::S_F_CHK:
            begin
                if (!stat.cur_start)
                begin
                    code_next  = ffha_pkg::ST_BADPTR;
                    state_next = ffha_pkg::S_RESP;
                end
                else if (!stat.cur_used)
                begin
                    code_next  = ffha_pkg::ST_DOUBLE;
                    state_next = ffha_pkg::S_RESP;
                end
                else
                begin
                    cmd.op     = ffha_pkg::OP_FREE_DEC;
                    code_next  = ffha_pkg::ST_FREED;
                    state_next = stat.nx_over ? ffha_pkg::S_F_W : ffha_pkg::S_F_LDN;
                end
            end
            ffha_pkg::S_F_LDN:
            begin
                cmd.op     = ffha_pkg::OP_RD_NX;
                state_next = ffha_pkg::S_F_DEC;
            end
            ffha_pkg::S_F_DEC:
            begin
                // read data lands this cycle; decide on the next cycle
                cmd.op     = ffha_pkg::OP_LD_NXT;
                state_next = ffha_pkg::S_F_W1;
            end
            ffha_pkg::S_F_W1:
            begin
                if (stat.nxt_used)
                begin
                    cmd.op     = ffha_pkg::OP_FREE_W;
                    state_next = ffha_pkg::S_RESP;
                end
                else
                begin
                    cmd.op     = ffha_pkg::OP_MERGE_W2;
                    state_next = ffha_pkg::S_M_W1_F;
                end
            end
            ffha_pkg::S_F_W:
            begin
                cmd.op     = ffha_pkg::OP_FREE_W;
                state_next = ffha_pkg::S_RESP;
            end
            ffha_pkg::S_M_W1_F:
            begin
                cmd.op     = ffha_pkg::OP_MERGE_W1;
                state_next = ffha_pkg::S_RESP;
            end
            ffha_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.res_en = 1'b1;
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default: state_next = ffha_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: stream ports, config port.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
//  channel   | signals                                  | beat carries
//  ----------+------------------------------------------+------------------------------
//  s_axis    | s_axis_tvalid/tready/tdata/tuser         | request: cmd, req_size, ptr
//  m_axis    | m_axis_tvalid/tready/tdata/tuser         | result: status, addr, used
//  cfg       | cfg_valid/cfg_ready/cfg_data             | split_slack
//
// After reset a clearing pass over all 16384 table entries (one entry per cycle)
// runs before the first request beat is taken; config writes are taken anytime.
// One request is worked on at a time; after each result is registered the
// controller returns to idle before the next beat is taken. A free rejects a
// malformed pointer before any table read, else reads and loads the block header
// and reports a non-start or double free; a real free writes the header back free
// and, unless it ends the pool, first reads its successor to merge with it if free.
// An allocate walks the blocks first-fit, with one table read, load and compare
// per block visited; if no block fits, a merge pass steps over the blocks and
// merges free neighbours, then a second walk follows.
// A finished result waits in the output register while m_axis stalls; the
// next request beat is taken once that result is registered.
`default_nettype none
module first_fit_heap_allocator_top (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [63:0]                   s_axis_tdata,  // req_size[31:0], ptr_offset[63:32]
    input  wire [0:0]                    s_axis_tuser,  // cmd[0]
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [39:0]                  m_axis_tdata,  // addr[15:0], used_bytes[32:16], zero
    output logic [2:0]                   m_axis_tuser,  // status[2:0]
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [ffha_pkg::SLACK_W-1:0]  cfg_data       // split_slack
);
    ffha_pkg::dp_cmd_t  dp_cmd;
    ffha_pkg::dp_stat_t dp_stat;
    ffha_pkg::status_t  res_status;
    logic [15:0]        res_addr;
    logic [ffha_pkg::SIZE_W-1:0] res_used;

    // config register is always writable
    assign cfg_ready = 1'b1;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    ffha_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .in_cmd     (s_axis_tuser[0]),
        .in_req     (s_axis_tdata[31:0]),
        .in_ptr     (s_axis_tdata[63:32]),
        .cfg_fire   (cfg_valid && cfg_ready),
        .cfg_slack  (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (res_status),
        .out_addr   (res_addr),
        .out_used   (res_used)
    );

    // pack the result beat
    assign m_axis_tuser = res_status;
    assign m_axis_tdata = {7'd0, res_used, res_addr};

endmodule
`default_nettype wire

// ===== rtl/core/ffha_checker.sv =====
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_top.
`default_nettype none
module ffha_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser
);
    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed under stall");

    // one request in flight: no second beat right after a taken one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one still in work");

    // status code stays in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= 3'(ffha_pkg::ST_DOUBLE))
        else $error("status code out of range");

    // address only on a successful allocate
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != 3'(ffha_pkg::ST_ALLOC) |-> m_axis_tdata[15:0] == 16'd0)
        else $error("nonzero address on a non-allocate result");

    // allocated payload never sits inside the first header
    a_addr_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == 3'(ffha_pkg::ST_ALLOC)
        |-> m_axis_tdata[15:0] >= 16'(ffha_pkg::HDR_BYTES))
        else $error("allocated address below header size");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
